[rtl/pss_pkg.sv]
// shared constants, codes and types for the packed symbol store
`default_nettype none

package pss_pkg;

  localparam int WORD_BITS           = 64;
  localparam int SHIFT_BITS          = 6;
  localparam int WIDTH_BITS          = 6;
  localparam int COUNT_BITS          = 17;
  localparam int INDEX_BITS          = 16;
  localparam int VALUE_BITS          = 63;
  localparam int BIT_POS_BITS        = INDEX_BITS + WIDTH_BITS;
  localparam int WORD_ADDR_BITS      = BIT_POS_BITS - SHIFT_BITS;
  localparam int CFG_INDEX_BITS      = 1;
  localparam int CFG_DATA_BITS       = COUNT_BITS;
  localparam int STORE_WORDS_DEFAULT = 1024;

  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 6'd8;
  localparam logic [COUNT_BITS-1:0] COUNT_RESET = 17'h10000;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_SYMBOL_WIDTH = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SYMBOL_COUNT = 1'd1;

  typedef struct packed {
    logic [SHIFT_BITS-1:0] shift;
    logic [WIDTH_BITS-1:0] width;
    logic                  span;
  } pss_merge_ctl_t;

  // row index width of a bank, at least one bit
  function automatic int row_bits(input int depth);
    int b;
    b = $clog2(depth);
    return (b < 1) ? 1 : b;
  endfunction

endpackage

`default_nettype wire

[rtl/pss_bank.sv]
// one bank of 64-bit words, one write port and one registered read port
`default_nettype none

module pss_bank #(
  parameter int DEPTH = 512,
  parameter int ROW_BITS = 9
) (
  input  wire logic                         clk,
  input  wire logic                         rd_en,
  input  wire logic [ROW_BITS-1:0]          rd_row,
  output      logic [pss_pkg::WORD_BITS-1:0] rd_data,
  input  wire logic                         wr_en,
  input  wire logic [ROW_BITS-1:0]          wr_row,
  input  wire logic [pss_pkg::WORD_BITS-1:0] wr_data
);
  import pss_pkg::*;

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_row];
    end
  end

endmodule

`default_nettype wire

[rtl/pss_merge.sv]
// symbol extract and masked insert over a pair of adjacent words
`default_nettype none

module pss_merge (
  input  wire logic [pss_pkg::WORD_BITS-1:0]  lo_word,
  input  wire logic [pss_pkg::WORD_BITS-1:0]  hi_word,
  input  wire logic [pss_pkg::VALUE_BITS-1:0] value,
  input  wire pss_pkg::pss_merge_ctl_t        ctl,
  output      logic [pss_pkg::VALUE_BITS-1:0] symbol,
  output      logic [pss_pkg::WORD_BITS-1:0]  new_lo,
  output      logic [pss_pkg::WORD_BITS-1:0]  new_hi
);
  import pss_pkg::*;

  logic [WORD_BITS-1:0]   mask;
  logic [2*WORD_BITS-1:0] pair;
  logic [2*WORD_BITS-1:0] extracted;
  logic [2*WORD_BITS-1:0] field_mask;
  logic [2*WORD_BITS-1:0] field_value;
  logic [2*WORD_BITS-1:0] merged;
  logic [WORD_BITS-1:0]   sym_word;

  always_comb begin
    mask        = (WORD_BITS'(1) << ctl.width) - WORD_BITS'(1);
    // upper word only counts when the symbol crosses into it
    pair        = {(ctl.span ? hi_word : {WORD_BITS{1'b0}}), lo_word};
    extracted   = pair >> ctl.shift;
    sym_word    = extracted[WORD_BITS-1:0] & mask;
    symbol      = sym_word[VALUE_BITS-1:0];
    field_mask  = {{WORD_BITS{1'b0}}, mask} << ctl.shift;
    field_value = {{WORD_BITS{1'b0}}, {1'b0, value} & mask} << ctl.shift;
    merged      = ({hi_word, lo_word} & ~field_mask) | field_value;
    new_lo      = merged[WORD_BITS-1:0];
    new_hi      = merged[2*WORD_BITS-1:WORD_BITS];
  end

endmodule

`default_nettype wire

[rtl/packed_symbol_store.sv]
// top level of the packed symbol store: control, configuration and banks
//
//   channel   direction  handshake                 payload
//   input     in         in_valid / in_ready       opcode, symbol_index, write_value
//   output    out        out_valid / out_ready     read_data, range_error
//   config    in         cfg_write_en (no wait)    cfg_index, cfg_data
//
// an item is accepted in S_IDLE, which computes the word address and issues reads to
// the word banks that hold the symbol; S_MERGE then merges and, for a write, writes back.
// the result then waits in the output register; a new request is taken meanwhile,
// but its merge stalls while the previous result has not been taken.
// after reset a clearing pass over ceil(STORE_WORDS/2) rows zeroes the banks, no
// requests are taken then; configuration writes are taken at any time.
`default_nettype none

module packed_symbol_store #(
  parameter int STORE_WORDS = pss_pkg::STORE_WORDS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output      logic                              in_ready,
  input  wire logic                              opcode,
  input  wire logic [pss_pkg::INDEX_BITS-1:0]    symbol_index,
  input  wire logic [pss_pkg::VALUE_BITS-1:0]    write_value,
  output      logic                              out_valid,
  input  wire logic                              out_ready,
  output      logic [pss_pkg::VALUE_BITS-1:0]    read_data,
  output      logic                              range_error,
  input  wire logic                              cfg_write_en,
  input  wire logic [pss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [pss_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import pss_pkg::*;

  localparam int EVEN_DEPTH = (STORE_WORDS + 1) / 2;
  localparam int ODD_DEPTH  = STORE_WORDS / 2;
  localparam int EVEN_BITS  = row_bits(EVEN_DEPTH);
  localparam int ODD_BITS   = row_bits(ODD_DEPTH);
  localparam int END_BITS   = BIT_POS_BITS + 1;
  localparam logic [END_BITS-1:0] STORE_BITS = END_BITS'(STORE_WORDS * WORD_BITS);
  localparam logic [EVEN_BITS-1:0] CLEAR_LAST = EVEN_BITS'(EVEN_DEPTH - 1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_MERGE} state_t;

  state_t state;

  logic [WIDTH_BITS-1:0] symbol_width;
  logic [COUNT_BITS-1:0] symbol_count;
  logic [EVEN_BITS-1:0]  clr_row;

  // request held from accept to merge
  logic                  op_q;
  logic [VALUE_BITS-1:0] value_q;
  logic                  err_q;
  logic                  empty_q;
  logic                  first_odd_q;
  logic [EVEN_BITS-1:0]  even_row_q;
  logic [ODD_BITS-1:0]   odd_row_q;
  pss_merge_ctl_t        ctl_q;

  logic                      accept;
  logic [BIT_POS_BITS-1:0]   start_bit;
  logic [END_BITS-1:0]       bit_to;
  logic [WORD_ADDR_BITS-1:0] first_word;
  logic [WORD_ADDR_BITS:0]   first_plus;
  logic [SHIFT_BITS:0]       shift_end;
  logic                      req_err;
  logic                      req_empty;
  logic                      req_span;
  logic                      req_live;
  pss_merge_ctl_t            req_ctl;

  logic                  even_rd_en;
  logic                  odd_rd_en;
  logic [EVEN_BITS-1:0]  even_rd_row;
  logic [ODD_BITS-1:0]   odd_rd_row;
  logic [WORD_BITS-1:0]  even_rd_data;
  logic [WORD_BITS-1:0]  odd_rd_data;
  logic                  even_wr_en;
  logic                  odd_wr_en;
  logic [EVEN_BITS-1:0]  even_wr_row;
  logic [ODD_BITS-1:0]   odd_wr_row;
  logic [WORD_BITS-1:0]  even_wr_data;
  logic [WORD_BITS-1:0]  odd_wr_data;

  logic [WORD_BITS-1:0]  lo_word;
  logic [WORD_BITS-1:0]  hi_word;
  logic [VALUE_BITS-1:0] merge_symbol;
  logic [WORD_BITS-1:0]  new_lo;
  logic [WORD_BITS-1:0]  new_hi;
  logic                  merge_go;
  logic                  do_write;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign merge_go = (state == S_MERGE) && (!out_valid || out_ready);

  // address decode of the incoming request
  always_comb begin
    start_bit  = BIT_POS_BITS'(symbol_index) * BIT_POS_BITS'(symbol_width);
    bit_to     = {1'b0, start_bit} + END_BITS'(symbol_width);
    first_word = start_bit[BIT_POS_BITS-1:SHIFT_BITS];
    first_plus = {1'b0, first_word} + (WORD_ADDR_BITS + 1)'(1);
    shift_end  = {1'b0, start_bit[SHIFT_BITS-1:0]} + {1'b0, symbol_width};
    req_err    = ({1'b0, symbol_index} >= symbol_count) || (bit_to > STORE_BITS);
    req_empty  = (symbol_width == '0);
    req_span   = (shift_end > (SHIFT_BITS + 1)'(WORD_BITS));
    req_live   = accept && !req_err && !req_empty;
    req_ctl.shift = start_bit[SHIFT_BITS-1:0];
    req_ctl.width = symbol_width;
    req_ctl.span  = req_span;
    // word f and f+1 sit in opposite banks
    odd_rd_row  = first_word[ODD_BITS:1];
    even_rd_row = first_plus[EVEN_BITS:1];
    even_rd_en  = req_live && (!first_word[0] || req_span);
    odd_rd_en   = req_live && (first_word[0] || req_span);
  end

  always_comb begin
    lo_word = first_odd_q ? odd_rd_data : even_rd_data;
    hi_word = first_odd_q ? even_rd_data : odd_rd_data;
  end

  pss_merge u_merge (
    .lo_word (lo_word),
    .hi_word (hi_word),
    .value   (value_q),
    .ctl     (ctl_q),
    .symbol  (merge_symbol),
    .new_lo  (new_lo),
    .new_hi  (new_hi)
  );

  // bank write ports: zero sweep after reset, otherwise write-back
  always_comb begin
    do_write = merge_go && (op_q == OP_WRITE) && !err_q && !empty_q;
    if (state == S_CLEAR) begin
      even_wr_en   = 1'b1;
      odd_wr_en    = (32'(clr_row) < ODD_DEPTH);
      even_wr_row  = clr_row;
      odd_wr_row   = clr_row[ODD_BITS-1:0];
      even_wr_data = '0;
      odd_wr_data  = '0;
    end else begin
      even_wr_en   = do_write && (!first_odd_q || ctl_q.span);
      odd_wr_en    = do_write && (first_odd_q || ctl_q.span);
      even_wr_row  = even_row_q;
      odd_wr_row   = odd_row_q;
      even_wr_data = first_odd_q ? new_hi : new_lo;
      odd_wr_data  = first_odd_q ? new_lo : new_hi;
    end
  end

  pss_bank #(
    .DEPTH    (EVEN_DEPTH),
    .ROW_BITS (EVEN_BITS)
  ) u_even (
    .clk     (clk),
    .rd_en   (even_rd_en),
    .rd_row  (even_rd_row),
    .rd_data (even_rd_data),
    .wr_en   (even_wr_en),
    .wr_row  (even_wr_row),
    .wr_data (even_wr_data)
  );

  pss_bank #(
    .DEPTH    (ODD_DEPTH),
    .ROW_BITS (ODD_BITS)
  ) u_odd (
    .clk     (clk),
    .rd_en   (odd_rd_en),
    .rd_row  (odd_rd_row),
    .rd_data (odd_rd_data),
    .wr_en   (odd_wr_en),
    .wr_row  (odd_wr_row),
    .wr_data (odd_wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_width <= WIDTH_RESET;
      symbol_count <= COUNT_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_SYMBOL_WIDTH: symbol_width <= cfg_data[WIDTH_BITS-1:0];
        CFG_SYMBOL_COUNT: symbol_count <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q        <= opcode;
      value_q     <= write_value;
      err_q       <= req_err;
      empty_q     <= req_empty;
      first_odd_q <= first_word[0];
      even_row_q  <= even_rd_row;
      odd_row_q   <= odd_rd_row;
      ctl_q       <= req_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_row   <= '0;
      out_valid <= 1'b0;
    end else begin
      // a merge in the same cycle refills the output register
      if (out_valid && out_ready && !merge_go) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_row <= clr_row + EVEN_BITS'(1);
          if (clr_row == CLEAR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_MERGE;
          end
        end
        S_MERGE: begin
          if (merge_go) begin
            out_valid   <= 1'b1;
            range_error <= err_q;
            read_data   <= (err_q || empty_q || (op_q == OP_WRITE)) ? '0 : merge_symbol;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the banks are never written in the cycle that issues a new read
  a_no_write_on_accept: assert property (@(posedge clk) disable iff (rst)
    accept |-> !(even_wr_en || odd_wr_en))
    else $error("bank write overlaps request accept");

  a_accept_to_merge: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_MERGE))
    else $error("accepted request did not move to merge");

  a_two_bank_write_spans: assert property (@(posedge clk) disable iff (rst)
    (state == S_MERGE) && even_wr_en && odd_wr_en |-> ctl_q.span)
    else $error("both banks written for a symbol that does not span");

  a_error_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> (read_data == '0))
    else $error("refused request returned data");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !in_ready)
    else $error("request taken during clearing pass");

endmodule

`default_nettype wire

[test/packed_symbol_store_tb.sv]
// self-checking testbench for the packed symbol store, with a scoreboard class and random traffic
`default_nettype none

module packed_symbol_store_tb;
  import pss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_WORDS = STORE_WORDS_DEFAULT;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_REQUESTS = 175;

  typedef struct {
    logic [VALUE_BITS-1:0] data;
    logic                  flag;
  } symbol_result_t;

  class symbol_scoreboard;
    bit [WORD_BITS-1:0] store_words [STORE_WORDS];
    int unsigned        layout_width;
    int unsigned        layout_count;
    symbol_result_t     expected_symbols [$];
    int unsigned        failures;

    function new();
      foreach (store_words[i]) store_words[i] = '0;
      layout_width = WIDTH_RESET;
      layout_count = COUNT_RESET;
      failures = 0;
    endfunction

    function void set_layout(int unsigned width, int unsigned count);
      layout_width = width & 32'h3f;
      layout_count = count & 32'h1ffff;
    endfunction

    function int unsigned outstanding();
      return expected_symbols.size();
    endfunction

    // predicts the result of an accepted request and updates the shadow store
    function void note_request(logic op, logic [INDEX_BITS-1:0] idx,
                               logic [VALUE_BITS-1:0] val);
      longint unsigned lo_bit;
      longint unsigned hi_bit;
      int unsigned     first;
      int unsigned     last;
      int unsigned     sh;
      bit [WORD_BITS-1:0] mask;
      bit [WORD_BITS-1:0] data;
      bit [WORD_BITS-1:0] v;
      symbol_result_t  res;
      res.data = '0;
      res.flag = 1'b0;
      mask = (layout_width == 0) ? '0 : (64'd1 << layout_width) - 64'd1;
      lo_bit = longint'(idx) * layout_width;
      hi_bit = lo_bit + layout_width;
      if (idx >= layout_count || hi_bit > STORE_WORDS * WORD_BITS) begin
        res.flag = 1'b1;
      end else if (layout_width != 0) begin
        first = int'(lo_bit >> 6);
        last = int'((hi_bit - 1) >> 6);
        sh = int'(lo_bit & 63);
        if (op == OP_READ) begin
          data = store_words[first] >> sh;
          if (last != first && sh != 0) data |= store_words[last] << (64 - sh);
          data &= mask;
          res.data = data[VALUE_BITS-1:0];
        end else begin
          v = {1'b0, val} & mask;
          store_words[first] = (store_words[first] & ~(mask << sh)) | (v << sh);
          // the upper part of a symbol that crosses into the next word
          if (last != first && sh != 0) begin
            store_words[last] = (store_words[last] & ~(mask >> (64 - sh))) | (v >> (64 - sh));
          end
        end
      end
      expected_symbols.push_back(res);
    endfunction

    function void check_result(logic [VALUE_BITS-1:0] data, logic flag);
      symbol_result_t exp_res;
      if (expected_symbols.size() == 0) begin
        $display("%0t: unexpected result read_data %h range_error %b", $time, data, flag);
        failures++;
        return;
      end
      exp_res = expected_symbols.pop_front();
      if (data !== exp_res.data) begin
        $display("%0t: read_data expected %h got %h", $time, exp_res.data, data);
        failures++;
      end
      if (flag !== exp_res.flag) begin
        $display("%0t: range_error expected %b got %b", $time, exp_res.flag, flag);
        failures++;
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic                      opcode;
  logic [INDEX_BITS-1:0]     symbol_index;
  logic [VALUE_BITS-1:0]     write_value;
  logic                      out_valid;
  logic                      out_ready;
  logic [VALUE_BITS-1:0]     read_data;
  logic                      range_error;
  logic                      cfg_write_en;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  symbol_scoreboard sb = new();
  bit               no_gaps;
  int unsigned      idle_cycles;

  packed_symbol_store #(.STORE_WORDS(STORE_WORDS)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .symbol_index (symbol_index),
    .write_value  (write_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .range_error  (range_error),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // entered and left at a falling edge; valid stays up for the caller to decide
  task automatic send_request(input logic op, input int unsigned idx,
                              input logic [VALUE_BITS-1:0] val);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    symbol_index <= idx[INDEX_BITS-1:0];
    write_value <= val;
    do @(posedge clk); while (!in_ready);
    sb.note_request(op, idx[INDEX_BITS-1:0], val);
    @(negedge clk);
  endtask

  task automatic drain_requests();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  task automatic write_layout(input int unsigned width, input int unsigned count);
    cfg_write_en <= 1'b1;
    cfg_index <= CFG_SYMBOL_WIDTH;
    cfg_data <= CFG_DATA_BITS'(width);
    @(negedge clk);
    cfg_index <= CFG_SYMBOL_COUNT;
    cfg_data <= CFG_DATA_BITS'(count);
    @(negedge clk);
    cfg_write_en <= 1'b0;
    sb.set_layout(width, count);
  endtask

  task automatic run_random_phase(input int unsigned n);
    int unsigned valid_lim;
    int unsigned win_base;
    int unsigned pick;
    int unsigned idx;
    logic        op;
    logic [VALUE_BITS-1:0] val;
    valid_lim = (sb.layout_count > 65536) ? 65536 : sb.layout_count;
    if (sb.layout_width != 0 && 65536 / sb.layout_width < valid_lim) begin
      valid_lim = 65536 / sb.layout_width;
    end
    win_base = (valid_lim == 0) ? 0 : $urandom_range(valid_lim - 1);
    repeat (n) begin
      pick = $urandom_range(99);
      // mostly a narrow window so that reads find earlier writes, some out of range
      if (valid_lim == 0 || pick >= 90) idx = $urandom_range(65535);
      else if (pick < 55) idx = (win_base + $urandom_range(47)) % valid_lim;
      else if (pick < 62) idx = valid_lim - 1 - ($urandom_range(3) % valid_lim);
      else idx = $urandom_range(valid_lim - 1);
      op = $urandom_range(1) ? OP_WRITE : OP_READ;
      case ($urandom_range(7))
        0: val = '1;
        1: val = '0;
        default: val = {$urandom, $urandom};
      endcase
      send_request(op, idx, val);
      if ($urandom_range(149) == 0) drain_requests();
    end
  endtask

  // receiver side: random stall before each result, then wait for it
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    @(negedge clk iff !rst);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(17);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(read_data, range_error);
      @(negedge clk);
    end
  end

  initial begin
    int unsigned width;
    int unsigned count;
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = OP_READ;
    symbol_index = '0;
    write_value = '0;
    cfg_write_en = 1'b0;
    cfg_index = CFG_SYMBOL_WIDTH;
    cfg_data = '0;
    no_gaps = 1'b0;
    idle_cycles = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset layout: 8-bit symbols, only the first 8192 fit in the store
    send_request(OP_READ, 0, '0);
    send_request(OP_WRITE, 0, '1);
    send_request(OP_READ, 0, '0);
    send_request(OP_WRITE, 8191, 63'h5555_5555_5555_5555);
    send_request(OP_READ, 8191, '0);
    send_request(OP_READ, 8192, '0);
    send_request(OP_WRITE, 65535, '1);
    // symbol 7 ends exactly on a word boundary
    send_request(OP_WRITE, 7, 63'h2aaa_aaaa_aaaa_aaa5);
    send_request(OP_READ, 8, '0);
    send_request(OP_READ, 7, '0);
    drain_requests();

    // widest symbols, crossing words
    write_layout(63, 65536);
    send_request(OP_WRITE, 1, '1);
    send_request(OP_WRITE, 0, 63'h2aaa_aaaa_aaaa_aaaa);
    send_request(OP_READ, 0, '0);
    send_request(OP_READ, 1, '0);
    send_request(OP_WRITE, 1039, 63'h5555_5555_5555_5555);
    send_request(OP_READ, 1039, '0);
    send_request(OP_WRITE, 1040, '1);
    drain_requests();

    // empty symbols
    write_layout(0, 5);
    send_request(OP_WRITE, 3, '1);
    send_request(OP_READ, 4, '0);
    send_request(OP_READ, 5, '0);
    drain_requests();

    // nothing in use
    write_layout(13, 0);
    send_request(OP_READ, 0, '0);
    send_request(OP_WRITE, 0, '1);
    drain_requests();

    write_layout(1, 1);
    send_request(OP_WRITE, 0, 63'h1);
    send_request(OP_READ, 0, '0);
    send_request(OP_READ, 1, '0);
    drain_requests();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin width = 1; count = 65536; end
        1: begin width = 63; count = 131071; end
        2: begin width = 32; count = 65536; end
        3: begin width = 5; count = $urandom_range(1, 300); end
        4: begin width = 0; count = 131071; end
        default: begin
          width = $urandom_range(1, 63);
          case ($urandom_range(3))
            0: count = 65536;
            1: count = 131071;
            2: count = $urandom_range(1, 65536);
            default: count = $urandom_range(1, 300);
          endcase
        end
      endcase
      write_layout(width, count);
      no_gaps = (p % 3 == 2);
      run_random_phase(PHASE_REQUESTS);
      drain_requests();
    end

    no_gaps = 1'b0;
    repeat (4) @(posedge clk);
    if (sb.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
